### hdl/hdfg_pkg.sv
// Package for the haptic drive frame generator.
// Holds the register map, reset values, report and command codes and the
// shared widths. No dependencies.
package hdfg_pkg;

   localparam int unsigned MAG_W    = 16;
   localparam int unsigned CEIL_W   = 11;
   localparam int unsigned FREQ_W   = 10;
   localparam int unsigned AMP_W    = 10;
   localparam int unsigned SEQ_W    = 4;
   localparam int unsigned FRAME_W  = 40;
   localparam int unsigned PROD_W   = MAG_W + CEIL_W;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned REQ_DW   = 32;
   localparam int unsigned RSP_DW   = 48;

   localparam logic [AMP_W-1:0]  AMP_MAX        = 10'd1023;
   localparam logic [1:0]        KIND_RESET     = 2'd1;
   localparam logic [FREQ_W-1:0] HIGH_FREQ_RESET = 10'h187;
   localparam logic [FREQ_W-1:0] LOW_FREQ_RESET  = 10'h112;
   localparam logic [CEIL_W-1:0] CEILING_RESET   = 11'd450;

   // register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      REG_CONTROLLER_KIND   = 2'd0,
      REG_HIGH_BAND_FREQ    = 2'd1,
      REG_LOW_BAND_FREQ     = 2'd2,
      REG_AMPLITUDE_CEILING = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CTRL_ONOFF  = 2'd0,
      CTRL_SINGLE = 2'd1,
      CTRL_DUAL   = 2'd2,
      CTRL_UNUSED = 2'd3
   } ctrl_kind_type;

   typedef enum logic [1:0] {
      RPT_NONE   = 2'd0,
      RPT_SINGLE = 2'd1,
      RPT_DUAL   = 2'd2,
      RPT_ONOFF  = 2'd3
   } report_kind_type;

   typedef enum logic [1:0] {
      CMD_OFF    = 2'd0,
      CMD_ON     = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_UNUSED = 2'd3
   } onoff_cmd_type;

   typedef enum logic {
      MODE_SET  = 1'b0,
      MODE_TICK = 1'b1
   } item_mode_type;

endpackage

### hdl/haptic_drive_frame_generator.sv
// Haptic drive frame generator: input register, one pass of update logic
// and an output register. Depends on hdfg_pkg.
//
// Usage:
//   req_ channel takes items. req_tuser is the mode: a set item latches new
//   strong/weak magnitudes, a tick item produces exactly one report on the
//   rsp_ channel. A set item produces nothing.
//   rsp_tuser carries the report kind (single frame, dual frame, on/off).
//   csr_ is an APB-style port with four registers at byte addresses 0, 4, 8
//   and 12: controller kind, high band frequency, low band frequency and
//   amplitude ceiling. Write them only while no item is in flight.
// Timing:
//   A tick reaches rsp_ through the input register, which loads at acceptance,
//   and then the output register, which loads once the output side is free. One
//   item per cycle is sustained while the output is not stalled; the single update
//   stage holds the sigma-delta accumulator and the amplitude multipliers, so that
//   stage sets the rate.
// Stall and reset:
//   While rsp_tready is low a waiting report holds; one more item sits in
//   the input register and set items keep draining past the stalled output.
//   Reset clears the sequence count, the levels and the accumulator and
//   loads the register defaults (single pair kind, 391, 274, 450).
module haptic_drive_frame_generator
   import hdfg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // heavy_mag[15:0], light_mag[31:16]
   input  logic              req_tuser,   // mode[0]
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // sequence_tag[3:0], onoff_command[5:4],
                                          // haptic_frame[45:6], active[46], zero[47]
   output logic [1:0]        rsp_tuser,   // report_kind[1:0]
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // configuration
   logic [1:0]        ctrl_kind_ff;
   logic [FREQ_W-1:0] high_freq_ff;
   logic [FREQ_W-1:0] low_freq_ff;
   logic [CEIL_W-1:0] ceiling_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic [MAG_W-1:0]  in_strong_ff, in_weak_ff;

   // state
   logic [SEQ_W-1:0]  seq_count_ff, seq_count_in;
   logic [MAG_W-1:0]  level_ff, level_in;
   logic [MAG_W-1:0]  error_ff, error_in;
   logic [AMP_W-1:0]  high_amp_ff, high_amp_in;
   logic [AMP_W-1:0]  low_amp_ff, low_amp_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   report_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]  rsp_tag_ff;
   onoff_cmd_type     rsp_cmd_ff, rsp_cmd_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic              rsp_active_ff, rsp_active_in;

   logic              advance;
   logic              out_load;
   logic              is_tick;
   logic [MAG_W-1:0]  weak_half;
   logic [PROD_W-1:0] prod_strong, prod_weak;
   logic [CEIL_W-1:0] scaled_strong, scaled_weak;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_CONTROLLER_KIND:   csr_prdata = {{(CSR_DW-2){1'b0}}, ctrl_kind_ff};
         REG_HIGH_BAND_FREQ:    csr_prdata = {{(CSR_DW-FREQ_W){1'b0}}, high_freq_ff};
         REG_LOW_BAND_FREQ:     csr_prdata = {{(CSR_DW-FREQ_W){1'b0}}, low_freq_ff};
         REG_AMPLITUDE_CEILING: csr_prdata = {{(CSR_DW-CEIL_W){1'b0}}, ceiling_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_kind_ff <= KIND_RESET;
         high_freq_ff <= HIGH_FREQ_RESET;
         low_freq_ff  <= LOW_FREQ_RESET;
         ceiling_ff   <= CEILING_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CONTROLLER_KIND:   ctrl_kind_ff <= csr_pwdata[1:0];
            REG_HIGH_BAND_FREQ:    high_freq_ff <= csr_pwdata[FREQ_W-1:0];
            REG_LOW_BAND_FREQ:     low_freq_ff  <= csr_pwdata[FREQ_W-1:0];
            REG_AMPLITUDE_CEILING: ceiling_ff   <= csr_pwdata[CEIL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- handshake
   assign is_tick    = (in_mode_ff == MODE_TICK);
   // a set item never waits for the output side
   assign advance    = in_valid_ff & (~is_tick | ~rsp_valid_ff | rsp_tready);
   assign out_load   = advance & is_tick;
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // --------------------------------------------------------- update pass
   assign weak_half     = in_weak_ff >> 1;
   assign prod_strong   = PROD_W'(in_strong_ff) * PROD_W'(ceiling_ff);
   assign prod_weak     = PROD_W'(in_weak_ff) * PROD_W'(ceiling_ff);
   assign scaled_strong = prod_strong[PROD_W-1:MAG_W];
   assign scaled_weak   = prod_weak[PROD_W-1:MAG_W];

   always_comb begin
      seq_count_in  = seq_count_ff;
      level_in      = level_ff;
      error_in      = error_ff;
      high_amp_in   = high_amp_ff;
      low_amp_in    = low_amp_ff;
      rsp_kind_in   = RPT_SINGLE;
      rsp_cmd_in    = CMD_OFF;
      rsp_frame_in  = '0;
      rsp_active_in = 1'b0;

      if (advance && !is_tick) begin
         if (ctrl_kind_type'(ctrl_kind_ff) == CTRL_ONOFF) begin
            level_in = (in_strong_ff > weak_half) ? in_strong_ff : weak_half;
         end else begin
            // saturate the scaled amplitude to ten bits
            high_amp_in = scaled_weak[CEIL_W-1] ? AMP_MAX : scaled_weak[AMP_W-1:0];
            low_amp_in  = scaled_strong[CEIL_W-1] ? AMP_MAX : scaled_strong[AMP_W-1:0];
         end
      end

      if (out_load) begin
         seq_count_in = seq_count_ff + SEQ_W'(1);
         case (ctrl_kind_type'(ctrl_kind_ff))
            CTRL_ONOFF: begin
               rsp_kind_in = RPT_ONOFF;
               if (level_ff == '0) begin
                  rsp_cmd_in = CMD_STOP;
                  error_in   = '0;
               end else if (error_ff < level_ff) begin
                  rsp_cmd_in    = CMD_ON;
                  error_in      = error_ff + ~level_ff;
                  rsp_active_in = 1'b1;
               end else begin
                  rsp_cmd_in    = CMD_OFF;
                  error_in      = error_ff - level_ff;
                  rsp_active_in = 1'b1;
               end
            end
            CTRL_DUAL: begin
               rsp_kind_in   = RPT_DUAL;
               rsp_frame_in  = {low_amp_ff, low_freq_ff, high_amp_ff, high_freq_ff};
               rsp_active_in = (high_amp_ff != '0) | (low_amp_ff != '0);
            end
            default: begin
               rsp_kind_in   = RPT_SINGLE;
               rsp_frame_in  = {low_amp_ff, low_freq_ff, high_amp_ff, high_freq_ff};
               rsp_active_in = (high_amp_ff != '0) | (low_amp_ff != '0);
            end
         endcase
      end
   end

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_count_ff <= '0;
         level_ff     <= '0;
         error_ff     <= '0;
         high_amp_ff  <= '0;
         low_amp_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_count_ff <= seq_count_in;
         level_ff     <= level_in;
         error_ff     <= error_in;
         high_amp_ff  <= high_amp_in;
         low_amp_ff   <= low_amp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff   <= req_tuser;
         in_strong_ff <= req_tdata[MAG_W-1:0];
         in_weak_ff   <= req_tdata[2*MAG_W-1:MAG_W];
      end
      if (out_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_tag_ff    <= seq_count_ff;
         rsp_cmd_ff    <= rsp_cmd_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_active_ff <= rsp_active_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_active_ff, rsp_frame_ff, rsp_cmd_ff, rsp_tag_ff};

   // ---------------------------------------------------------- assertions
   // the sequence count always runs one ahead of the report on show
   a_tag_follows_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> seq_count_ff == rsp_tag_ff + SEQ_W'(1))
      else $error("sequence count out of step with report tag");

   // on/off reports carry no frame
   a_onoff_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RPT_ONOFF |-> rsp_frame_ff == '0)
      else $error("frame bits set in on/off report");

   // an idle on/off report is always a stop
   a_idle_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RPT_ONOFF && !rsp_active_ff
         |-> rsp_cmd_ff == CMD_STOP)
      else $error("inactive on/off report without stop command");

   // a stop leaves the accumulator cleared
   a_stop_clears_error: assert property (@(posedge clock) disable iff (reset)
      out_load && rsp_cmd_in == CMD_STOP && rsp_kind_in == RPT_ONOFF
         |=> error_ff == '0)
      else $error("accumulator not cleared after stop");

endmodule
